/* design/rstpm_pkg.sv */
// ----------------------------------------------------------------------------
// rstpm_pkg
// Shared types, constants and the elaboration-time trig series for the
// range-scan touch-point mapper.
// ----------------------------------------------------------------------------
package rstpm_pkg;

  // default build constants
  localparam int STEPS_PER_TURN_DEF = 1024;
  localparam int CELL_SIZE_DEF      = 10;

  // field widths
  localparam int IDX_W   = 9;
  localparam int RANGE_W = 16;
  localparam int MAG_W   = 16;   // unsigned Q1.15 magnitude, 32768 = 1.0
  localparam int V_W     = 11;   // |x|, |y| after the range filter (< 1319)
  localparam int CELL_W  = 7;
  localparam int TILE_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_SHAPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 1'd1;

  // screen shape codes
  localparam logic [1:0] SHAPE_SQUARE = 2'd0;
  localparam logic [1:0] SHAPE_VERT   = 2'd1;
  localparam logic [1:0] SHAPE_HORIZ  = 2'd2;

  // screen geometry
  localparam logic [V_W-1:0]     SIZE_SQUARE = 11'd640;
  localparam logic [V_W-1:0]     SIZE_LONG   = 11'd1280;
  localparam logic [V_W-1:0]     SIZE_SHORT  = 11'd320;
  localparam logic [RANGE_W-1:0] DIAG_SQUARE = 16'd905;
  localparam logic [RANGE_W-1:0] DIAG_RECT   = 16'd1319;
  localparam logic [RANGE_W-1:0] NEAR_LIMIT_RESET = 16'd20;

  // tile thresholds
  localparam logic [CELL_W-1:0] TILE_T1 = 7'd32;
  localparam logic [CELL_W-1:0] TILE_T2 = 7'd64;
  localparam logic [CELL_W-1:0] TILE_T3 = 7'd96;
  localparam logic [CELL_W-1:0] CELL_MAX = 7'd127;

  localparam logic [TILE_W-1:0] TILE_0 = 2'd0;
  localparam logic [TILE_W-1:0] TILE_1 = 2'd1;
  localparam logic [TILE_W-1:0] TILE_2 = 2'd2;
  localparam logic [TILE_W-1:0] TILE_3 = 2'd3;

  // pi/2 and 1.0 in Q2.30
  localparam logic [63:0] HP_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [MAG_W-1:0] s;
    logic [MAG_W-1:0] c;
  } trig_t;

  // clamp to [0, 1.0] and round half up to Q1.15
  function automatic logic [MAG_W-1:0] to_q15(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t < 0) t = 0;
    if (t > signed'(ONE_Q30)) t = signed'(ONE_Q30);
    return MAG_W'((64'(t) + 64'd16384) >> 15);
  endfunction

  // taylor series for sin/cos within one quadrant, used for table build only
  function automatic trig_t quad_trig(input logic [63:0] phi);
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    trig_t              res;
    x2 = (phi * phi) >> 30;
    ts = phi;
    tc = ONE_Q30;
    ss = signed'(phi);
    cs = signed'(ONE_Q30);
    for (int k = 1; k <= 7; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k & 1) != 0) begin
        ss = ss - signed'(ts);
        cs = cs - signed'(tc);
      end else begin
        ss = ss + signed'(ts);
        cs = cs + signed'(tc);
      end
    end
    res.s = to_q15(ss);
    res.c = to_q15(cs);
    return res;
  endfunction

endpackage

/* design/range_scan_touch_point_mapper.sv */
// path: a word accepted into the input register passes stages 1, 2 and 3, then the output register
// throughput: one word per cycle unless the master side holds off; five register stages each advance on their own,
// so bubbles close up while the output register waits
// stages split the cos/sin lookup, the 16x16 multiplies and the reciprocal divide
// reset (rst, synchronous): pipeline empty, screen_shape square, near limit 20 mm,
// last cell (0,0)
// ----------------------------------------------------------------------------
// range_scan_touch_point_mapper
// Maps scanner range samples to screen cells, drops out-of-screen and repeated
// cells, and tags each cell with its display tile.
// ----------------------------------------------------------------------------
module range_scan_touch_point_mapper #(
  parameter int STEPS_PER_TURN = rstpm_pkg::STEPS_PER_TURN_DEF,
  parameter int CELL_SIZE      = rstpm_pkg::CELL_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // step_index [8:0], range_mm [24:9], zero fill
  input  logic [rstpm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cell_x [6:0], cell_y [13:7], tile [15:14]
  output logic [rstpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rstpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rstpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rstpm_pkg::*;

  localparam int G_SH      = (STEPS_PER_TURN % 4 == 0) ? 2 :
                             ((STEPS_PER_TURN % 2 == 0) ? 1 : 0);
  localparam int TBL_DEPTH = STEPS_PER_TURN / (1 << G_SH);
  localparam int TI_W      = $clog2(TBL_DEPTH);
  localparam int M_W       = $clog2(STEPS_PER_TURN);
  localparam int QW        = M_W + 3;
  localparam int DIV_K     = 17;
  localparam int RECIP_W   = DIV_K + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_K) / CELL_SIZE);
  localparam logic [V_W-1:0]     CELL_V  = V_W'(CELL_SIZE);
  localparam logic [QW-1:0]      STEPS_1 = QW'(STEPS_PER_TURN);
  localparam logic [QW-1:0]      STEPS_2 = QW'(2 * STEPS_PER_TURN);
  localparam logic [QW-1:0]      STEPS_3 = QW'(3 * STEPS_PER_TURN);

  // quadrant cos/sin table, one entry per reachable in-quadrant step
  logic [MAG_W-1:0] sin_tbl [TBL_DEPTH];
  logic [MAG_W-1:0] cos_tbl [TBL_DEPTH];

  for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_tbl
    localparam logic [63:0] PHI = (64'(i * (1 << G_SH)) * HP_Q30) / 64'(STEPS_PER_TURN);
    localparam trig_t       TRIG = quad_trig(PHI);
    assign sin_tbl[i] = TRIG.s;
    assign cos_tbl[i] = TRIG.c;
  end

  // configuration
  logic [1:0]         screen_shape;
  logic [RANGE_W-1:0] near_limit_mm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_shape  <= SHAPE_SQUARE;
      near_limit_mm <= NEAR_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_SHAPE: screen_shape  <= cfg_data[1:0];
        REG_NEAR_LIMIT:   near_limit_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // screen geometry for the current shape, code 3 acts as square
  logic [V_W-1:0]     max_x;
  logic [V_W-1:0]     max_y;
  logic [RANGE_W-1:0] max_d;

  always_comb begin
    case (screen_shape)
      SHAPE_VERT: begin
        max_x = SIZE_LONG;
        max_y = SIZE_SHORT;
        max_d = DIAG_RECT;
      end
      SHAPE_HORIZ: begin
        max_x = SIZE_SHORT;
        max_y = SIZE_LONG;
        max_d = DIAG_RECT;
      end
      default: begin
        max_x = SIZE_SQUARE;
        max_y = SIZE_SQUARE;
        max_d = DIAG_SQUARE;
      end
    endcase
  end

  // pipeline advance, each stage moves when it is empty or its successor moves
  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3, en_out;

  assign en_out        = !m_axis_tvalid || m_axis_tready;
  assign en3           = !v3 || en_out;
  assign en2           = !v2 || en3;
  assign en1           = !v1 || en2;
  assign en0           = !v0 || en1;
  assign s_axis_tready = en0;

  // stage 0: input register
  logic [IDX_W-1:0]   idx0;
  logic [RANGE_W-1:0] rng0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= s_axis_tvalid;
    end
    if (en0 && s_axis_tvalid) begin
      idx0 <= s_axis_tdata[IDX_W-1:0];
      rng0 <= s_axis_tdata[IDX_W+RANGE_W-1:IDX_W];
    end
  end

  // angle reduction, quadrant split and table lookup
  logic [QW-1:0]    idx_ext;
  logic [QW-1:0]    r_mod;
  logic [QW-1:0]    r4;
  logic [1:0]       quad;
  logic [QW-1:0]    quad_off;
  logic [M_W-1:0]   m_val;
  logic [TI_W-1:0]  tbl_idx;
  logic [MAG_W-1:0] s_val;
  logic [MAG_W-1:0] c_val;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic             neg_x;
  logic             neg_y;
  logic             range_ok;

  always_comb begin
    idx_ext = QW'(idx0);
    // index is below twice a turn, one subtract wraps it
    r_mod   = (idx_ext >= STEPS_1) ? idx_ext - STEPS_1 : idx_ext;
    r4      = r_mod << 2;
    if (r4 >= STEPS_3) begin
      quad     = 2'd3;
      quad_off = STEPS_3;
    end else if (r4 >= STEPS_2) begin
      quad     = 2'd2;
      quad_off = STEPS_2;
    end else if (r4 >= STEPS_1) begin
      quad     = 2'd1;
      quad_off = STEPS_1;
    end else begin
      quad     = 2'd0;
      quad_off = '0;
    end
    m_val   = M_W'(r4 - quad_off);
    tbl_idx = TI_W'(m_val >> G_SH);
    s_val   = sin_tbl[tbl_idx];
    c_val   = cos_tbl[tbl_idx];
    case (quad)
      2'd0: begin
        mag_x = c_val; neg_x = 1'b0;
        mag_y = s_val; neg_y = 1'b0;
      end
      2'd1: begin
        mag_x = s_val; neg_x = 1'b1;
        mag_y = c_val; neg_y = 1'b0;
      end
      2'd2: begin
        mag_x = c_val; neg_x = 1'b1;
        mag_y = s_val; neg_y = 1'b1;
      end
      default: begin
        mag_x = s_val; neg_x = 1'b0;
        mag_y = c_val; neg_y = 1'b1;
      end
    endcase
    range_ok = (rng0 > near_limit_mm) && (rng0 < max_d);
  end

  // stage 1: magnitudes and signs
  logic [RANGE_W-1:0] rng1;
  logic [MAG_W-1:0]   magx1;
  logic [MAG_W-1:0]   magy1;
  logic               negx1;
  logic               negy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0 && range_ok;
    end
    if (en1) begin
      rng1  <= rng0;
      magx1 <= mag_x;
      magy1 <= mag_y;
      negx1 <= neg_x;
      negy1 <= neg_y;
    end
  end

  // stage 2: scaled coordinates, range below 1319 keeps them in 11 bits
  logic [RANGE_W+MAG_W-1:0] prod_x;
  logic [RANGE_W+MAG_W-1:0] prod_y;
  logic [V_W-1:0]           px2;
  logic [V_W-1:0]           py2;
  logic                     negx2;
  logic                     negy2;

  assign prod_x = rng1 * magx1;
  assign prod_y = rng1 * magy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      px2   <= V_W'(prod_x >> 15);
      py2   <= V_W'(prod_y >> 15);
      negx2 <= negx1;
      negy2 <= negy1;
    end
  end

  // screen bound and quotient estimate by reciprocal
  logic                   off_screen;
  logic [V_W+RECIP_W-1:0] qprod_x;
  logic [V_W+RECIP_W-1:0] qprod_y;

  assign off_screen = (!negx2 && (px2 >= max_x)) || (!negy2 && (py2 >= max_y));
  assign qprod_x    = px2 * RECIP;
  assign qprod_y    = py2 * RECIP;

  // stage 3
  logic [V_W-1:0] px3;
  logic [V_W-1:0] py3;
  logic [V_W-1:0] qx3;
  logic [V_W-1:0] qy3;
  logic           negx3;
  logic           negy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2 && !off_screen;
    end
    if (en3) begin
      px3   <= px2;
      py3   <= py2;
      qx3   <= V_W'(qprod_x >> DIV_K);
      qy3   <= V_W'(qprod_y >> DIV_K);
      negx3 <= negx2;
      negy3 <= negy2;
    end
  end

  // quotient correction, sign check, saturation, repeat filter and tile
  logic [CELL_W-1:0] last_cell_x;
  logic [CELL_W-1:0] last_cell_y;
  logic [V_W-1:0]    rem_x;
  logic [V_W-1:0]    rem_y;
  logic [V_W-1:0]    qx;
  logic [V_W-1:0]    qy;
  logic [CELL_W-1:0] cx;
  logic [CELL_W-1:0] cy;
  logic              neg_cell;
  logic              emit;
  logic [TILE_W-1:0] tile_sel;
  logic [CELL_W-1:0] route_v;

  always_comb begin
    rem_x    = px3 - V_W'(qx3 * CELL_V);
    rem_y    = py3 - V_W'(qy3 * CELL_V);
    qx       = (rem_x >= CELL_V) ? V_W'(qx3 + 1'b1) : qx3;
    qy       = (rem_y >= CELL_V) ? V_W'(qy3 + 1'b1) : qy3;
    // a negative coordinate below one cell truncates to cell zero and survives
    neg_cell = (negx3 && (qx != '0)) || (negy3 && (qy != '0));
    cx       = (qx > V_W'(CELL_MAX)) ? CELL_MAX : CELL_W'(qx);
    cy       = (qy > V_W'(CELL_MAX)) ? CELL_MAX : CELL_W'(qy);
    emit     = v3 && !neg_cell && ((cx != last_cell_x) || (cy != last_cell_y));

    route_v = (screen_shape == SHAPE_VERT) ? cy : cx;
    case (screen_shape)
      SHAPE_VERT, SHAPE_HORIZ: begin
        if (route_v < TILE_T1)      tile_sel = TILE_0;
        else if (route_v < TILE_T2) tile_sel = TILE_1;
        else if (route_v < TILE_T3) tile_sel = TILE_2;
        else                        tile_sel = TILE_3;
      end
      default: begin
        if (cy < TILE_T1) tile_sel = (cx < TILE_T1) ? TILE_0 : TILE_1;
        else              tile_sel = (cx < TILE_T1) ? TILE_2 : TILE_3;
      end
    endcase
  end

  // output register
  logic [CELL_W-1:0] out_cx;
  logic [CELL_W-1:0] out_cy;
  logic [TILE_W-1:0] out_tile;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      last_cell_x   <= '0;
      last_cell_y   <= '0;
    end else if (en_out) begin
      m_axis_tvalid <= emit;
      if (emit) begin
        last_cell_x <= cx;
        last_cell_y <= cy;
      end
    end
    if (en_out && emit) begin
      out_cx   <= cx;
      out_cy   <= cy;
      out_tile <= tile_sel;
    end
  end

  assign m_axis_tdata = {out_tile, out_cy, out_cx};

`ifndef ASSERT_OFF
  // the word on offer is always the last cell recorded for repeat filtering
  a_last_matches_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (last_cell_x == out_cx) && (last_cell_y == out_cy))
    else $error("repeat filter state differs from offered cell");

  // every shape routes the low corner cell to tile zero
  a_corner_tile: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_cx < TILE_T1) && (out_cy < TILE_T1)) |-> (out_tile == TILE_0))
    else $error("corner cell not routed to tile zero");

  // samples past the range filter are inside the longest diagonal
  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (rng1 < DIAG_RECT))
    else $error("range filter let a far sample through");

  // non-negative coordinates past the screen check fit the long side
  a_screen_bound: assert property (@(posedge clk) disable iff (rst)
    (v3 && !negx3) |-> (px3 < SIZE_LONG))
    else $error("screen check let an x coordinate through");
`endif

endmodule

/* tb/sv/touch_cell_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_cell_checker
// Watches the sample, cell and register channels of the touch-point mapper,
// maps every accepted sample to its expected cell and compares each cell word
// the block emits against the oldest one still due.
// ----------------------------------------------------------------------------
module touch_cell_checker #(
  parameter int STEPS_PER_TURN = rstpm_pkg::STEPS_PER_TURN_DEF,
  parameter int CELL_SIZE      = rstpm_pkg::CELL_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // step_index [8:0], range_mm [24:9], zero fill
  input  logic [rstpm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cell_x [6:0], cell_y [13:7], tile [15:14]
  input  logic [rstpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rstpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rstpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                cells_pending
);
  import rstpm_pkg::*;

  typedef longint unsigned u64_t;

  // msb first, so tile lands in the top bits as on the port
  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_x;
  } cell_word_t;

  localparam longint UNIT_Q30    = 1073741824;
  localparam u64_t   HALF_PI_Q30 = 64'd1686629713;

  cell_word_t        cells_due[$];
  cell_word_t        want_cell;
  cell_word_t        seen_cell;
  logic [1:0]        shape_q;
  logic [15:0]       near_q;
  logic [CELL_W-1:0] last_x;
  logic [CELL_W-1:0] last_y;
  int                errors;

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t: cell mismatch: %s", $realtime, what);
  endtask

  // clamp to [0, 1.0] in Q2.30, then round half up to Q1.15
  function automatic int unsigned round_q15(input longint v);
    longint t;
    t = v;
    if (t < 0) t = 0;
    if (t > UNIT_Q30) t = UNIT_Q30;
    return 32'((t + 16384) >>> 15);
  endfunction

  // series expansion within one quadrant, each term truncated as it is built
  function automatic void quadrant_sin_cos(input u64_t phi, output int unsigned s_mag,
                                           output int unsigned c_mag);
    u64_t   sq;
    u64_t   s_term;
    u64_t   c_term;
    longint s_sum;
    longint c_sum;
    sq     = (phi * phi) >> 30;
    s_term = phi;
    c_term = u64_t'(UNIT_Q30);
    s_sum  = longint'(phi);
    c_sum  = UNIT_Q30;
    for (int k = 1; k <= 7; k++) begin
      s_term = ((s_term * sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      c_term = ((c_term * sq) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k & 1) != 0) begin
        s_sum -= longint'(s_term);
        c_sum -= longint'(c_term);
      end else begin
        s_sum += longint'(s_term);
        c_sum += longint'(c_term);
      end
    end
    s_mag = round_q15(s_sum);
    c_mag = round_q15(c_sum);
  endfunction

  function automatic logic [TILE_W-1:0] tile_for(input logic [1:0] shape,
                                                 input logic [CELL_W-1:0] cx,
                                                 input logic [CELL_W-1:0] cy);
    logic [CELL_W-1:0] v;
    v = (shape == SHAPE_VERT) ? cy : cx;
    if (shape == SHAPE_VERT || shape == SHAPE_HORIZ) begin
      if (v < TILE_T1) return TILE_0;
      if (v < TILE_T2) return TILE_1;
      if (v < TILE_T3) return TILE_2;
      return TILE_3;
    end
    // square rule, the spare shape code lands here too
    if (cy < TILE_T1) return (cx < TILE_T1) ? TILE_0 : TILE_1;
    return (cx < TILE_T1) ? TILE_2 : TILE_3;
  endfunction

  // returns 1 when the sample yields a new cell, updating the last-cell state
  function automatic bit sample_to_cell(input logic [8:0] idx, input logic [15:0] rng,
                                        output cell_word_t res_word);
    longint      max_x;
    longint      max_y;
    longint      max_d;
    longint      x;
    longint      y;
    longint      cx;
    longint      cy;
    longint      by_cos;
    longint      by_sin;
    int unsigned r;
    int unsigned q;
    int unsigned m;
    int unsigned s_mag;
    int unsigned c_mag;
    u64_t        phi;
    res_word = '0;
    case (shape_q)
      SHAPE_VERT: begin
        max_x = SIZE_LONG;
        max_y = SIZE_SHORT;
        max_d = DIAG_RECT;
      end
      SHAPE_HORIZ: begin
        max_x = SIZE_SHORT;
        max_y = SIZE_LONG;
        max_d = DIAG_RECT;
      end
      default: begin
        max_x = SIZE_SQUARE;
        max_y = SIZE_SQUARE;
        max_d = DIAG_SQUARE;
      end
    endcase
    if (rng <= near_q || longint'(rng) >= max_d) return 1'b0;

    r   = idx % STEPS_PER_TURN;
    q   = (4 * r) / STEPS_PER_TURN;
    m   = 4 * r - q * STEPS_PER_TURN;
    phi = (u64_t'(m) * HALF_PI_Q30) / u64_t'(STEPS_PER_TURN);
    quadrant_sin_cos(phi, s_mag, c_mag);
    by_cos = longint'((u64_t'(rng) * c_mag) >> 15);
    by_sin = longint'((u64_t'(rng) * s_mag) >> 15);
    case (q & 3)
      0: begin x = by_cos;  y = by_sin;  end
      1: begin x = -by_sin; y = by_cos;  end
      2: begin x = -by_cos; y = -by_sin; end
      default: begin x = by_sin; y = -by_cos; end
    endcase
    if (x >= max_x || y >= max_y) return 1'b0;

    // signed divide truncates toward zero, small negatives become cell 0
    cx = x / CELL_SIZE;
    cy = y / CELL_SIZE;
    if (cx < 0 || cy < 0) return 1'b0;
    if (cx > CELL_MAX) cx = CELL_MAX;
    if (cy > CELL_MAX) cy = CELL_MAX;
    if (CELL_W'(cx) == last_x && CELL_W'(cy) == last_y) return 1'b0;

    last_x          = CELL_W'(cx);
    last_y          = CELL_W'(cy);
    res_word.cell_x = last_x;
    res_word.cell_y = last_y;
    res_word.tile   = tile_for(shape_q, last_x, last_y);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shape_q = SHAPE_SQUARE;
      near_q  = NEAR_LIMIT_RESET;
      last_x  = '0;
      last_y  = '0;
      cells_due.delete();
    end else begin
      // a sample can never leave in the edge it enters, so check outputs first
      if (m_axis_tvalid && m_axis_tready) begin
        seen_cell = m_axis_tdata;
        if (cells_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word x=%0d y=%0d tile=%0d",
                                    seen_cell.cell_x, seen_cell.cell_y, seen_cell.tile));
        end else begin
          want_cell = cells_due.pop_front();
          if (seen_cell.cell_x !== want_cell.cell_x)
            report_mismatch($sformatf("cell_x got %0d want %0d",
                                      seen_cell.cell_x, want_cell.cell_x));
          if (seen_cell.cell_y !== want_cell.cell_y)
            report_mismatch($sformatf("cell_y got %0d want %0d",
                                      seen_cell.cell_y, want_cell.cell_y));
          if (seen_cell.tile !== want_cell.tile)
            report_mismatch($sformatf("tile got %0d want %0d (cell %0d,%0d)",
                                      seen_cell.tile, want_cell.tile,
                                      want_cell.cell_x, want_cell.cell_y));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_SHAPE) shape_q = cfg_data[1:0];
        else if (cfg_index == REG_NEAR_LIMIT) near_q = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (sample_to_cell(s_axis_tdata[8:0], s_axis_tdata[24:9], want_cell))
          cells_due.push_back(want_cell);
      end
    end
    cells_pending <= cells_due.size();
    fail_count    <= errors;
  end

endmodule

/* tb/sv/tb_range_scan_touch_point_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_scan_touch_point_mapper
// Drives range samples through the touch-point mapper: a directed set of edge
// cases, then random samples under every screen shape and several near limits,
// with random idle bursts on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_range_scan_touch_point_mapper;
  import rstpm_pkg::*;

  localparam logic [1:0] SHAPE_SPARE   = 2'd3;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         LONG_STALL    = 300;
  localparam int         DIRECTED_N    = 22;
  localparam int         PHASES        = 8;
  localparam int         CHUNK         = 50;

  localparam int DIR_STEP [DIRECTED_N] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 128, 255,
    256, 257, 300, 384, 511, 511, 64, 192, 0, 256, 511
  };
  localparam int DIR_RANGE [DIRECTED_N] = '{
    0, 20, 21, 21, 904, 905, 65535, 639, 640, 904, 500,
    500, 500, 300, 800, 800, 65535, 450, 450, 21, 21, 21
  };

  localparam logic [1:0] PHASE_SHAPE [PHASES] = '{
    SHAPE_SQUARE, SHAPE_VERT, SHAPE_HORIZ, SHAPE_SPARE,
    SHAPE_VERT, SHAPE_HORIZ, SHAPE_SQUARE, SHAPE_VERT
  };
  localparam int PHASE_NEAR  [PHASES] = '{0, 20, 65535, 500, 1318, 100, 300, 0};
  localparam int PHASE_ITEMS [PHASES] = '{290, 290, 40, 290, 40, 290, 290, 290};

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;   // step_index [8:0], range_mm [24:9], zero fill
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;   // cell_x [6:0], cell_y [13:7], tile [15:14]
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  int                      fail_count;
  int                      cells_pending;

  bit gaps_on;
  bit bursts_on;
  int stall_reqs = 0;

  always #10 clk = ~clk;

  range_scan_touch_point_mapper dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  touch_cell_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .cells_pending (cells_pending)
  );

  // valid stays high across back-to-back words, only a gap lowers it
  task automatic send_sample(input logic [8:0] step, input logic [15:0] rng);
    s_axis_tdata  <= IN_DATA_W'({rng, step});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // dropped samples may still be in flight after the last cell, hence the settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (cells_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx, input int value);
    cfg_index <= reg_idx;
    cfg_data  <= CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_mode(input logic [1:0] shape, input int near);
    drain();
    write_reg(REG_SCREEN_SHAPE, int'(shape));
    write_reg(REG_NEAR_LIMIT, near);
    cfg_valid <= 1'b0;
  endtask

  // mostly inside the accepted window, some on its edges, some anywhere
  function automatic logic [15:0] pick_range(input logic [1:0] shape, input int near);
    int diag;
    int lo;
    int sel;
    diag = (shape == SHAPE_VERT || shape == SHAPE_HORIZ) ? int'(DIAG_RECT)
                                                         : int'(DIAG_SQUARE);
    lo  = near + 1;
    sel = $urandom_range(0, 9);
    if (sel < 7 && lo < diag) return 16'($urandom_range(lo, diag - 1));
    if (sel < 9) begin
      case ($urandom_range(0, 3))
        0:       return 16'(near);
        1:       return 16'(lo);
        2:       return 16'(diag - 1);
        default: return 16'(diag);
      endcase
    end
    return 16'($urandom());
  endfunction

  // first quadrant favored, the second one mostly lands on negative x
  function automatic logic [8:0] pick_step();
    if ($urandom_range(0, 9) < 7) return 9'($urandom_range(0, 255));
    return 9'($urandom_range(256, 511));
  endfunction

  initial begin : sink
    int stall_done;
    stall_done = 0;
    m_axis_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (stall_done != stall_reqs) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_done++;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [8:0]  step;
    logic [15:0] rng;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_SCREEN_SHAPE;
    cfg_data      <= '0;
    gaps_on    = 1'b0;
    bursts_on  = 1'b0;
    step = '0;
    rng  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: limits, repeats, diagonal, small and large negative x
    for (int i = 0; i < DIRECTED_N; i++)
      send_sample(9'(DIR_STEP[i]), 16'(DIR_RANGE[i]));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_mode(PHASE_SHAPE[p], PHASE_NEAR[p]);
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        if (i % CHUNK == 0) begin
          gaps_on   = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
          bursts_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
        end
        // output held off while words keep coming, so the pipe backs up
        if (p == 1 && i == 100) stall_reqs++;
        if (p == 5 && i == 150) drain();
        // a repeated sample checks the duplicate filter
        if (i == 0 || $urandom_range(0, 9) != 0) begin
          step = pick_step();
          rng  = pick_range(PHASE_SHAPE[p], PHASE_NEAR[p]);
        end
        send_sample(step, rng);
      end
    end
    drain();

    if (fail_count == 0 && cells_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/rstpm_pkg.sv
design/range_scan_touch_point_mapper.sv
tb/sv/touch_cell_checker.sv
tb/sv/tb_range_scan_touch_point_mapper.sv
